// File: hdl/sbde_pkg.sv
`timescale 1ns / 1ps

package sbde_pkg;

   localparam int MaxWidth  = 256;
   localparam int NumRows   = 6;
   localparam int CellW     = 3;
   localparam int ColW      = $clog2(MaxWidth);
   localparam int WidthW    = $clog2(MaxWidth + 1);
   // longest prefix is "#1!" plus three digits plus "~$#0"
   localparam int MaxPrefix = 10;
   localparam int PosW      = $clog2(MaxWidth + MaxPrefix + 1);
   localparam int PlaneW    = 4;
   localparam int RowW      = 3;
   localparam int LineW     = NumRows * CellW;
   localparam int CfgW      = 9;

   localparam logic [7:0] ChrBase   = 8'h3F;  // '?'
   localparam logic [7:0] ChrHash   = 8'h23;  // '#'
   localparam logic [7:0] ChrZero   = 8'h30;  // '0'
   localparam logic [7:0] ChrOne    = 8'h31;  // '1'
   localparam logic [7:0] ChrBang   = 8'h21;  // '!'
   localparam logic [7:0] ChrTilde  = 8'h7E;  // '~'
   localparam logic [7:0] ChrDollar = 8'h24;  // '$'
   localparam logic [7:0] ChrDash   = 8'h2D;  // '-'

   typedef enum logic [1:0] {
      ACT_PIXEL     = 2'd0,
      ACT_PULL      = 2'd1,
      ACT_NEW_IMAGE = 2'd2,
      ACT_NONE      = 2'd3
   } action_type;

   typedef enum logic {
      REG_IMAGE_WIDTH = 1'b0,
      REG_MONO_MODE   = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic               en;
      logic [ColW-1:0]    addr;
      logic [RowW-1:0]    row;
      logic [CellW-1:0]   code;
   } mem_wr_type;

   typedef struct packed {
      logic               is_column;
      logic [7:0]         out_byte;
      logic               band_end;
      logic               nothing_ready;
      logic [2:0]         plane;
      logic               mono;
   } issue_type;

   localparam logic [5:0] Bayer [64] = '{
      6'd0,  6'd32, 6'd8,  6'd40, 6'd2,  6'd34, 6'd10, 6'd42,
      6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26,
      6'd12, 6'd44, 6'd4,  6'd36, 6'd14, 6'd46, 6'd6,  6'd38,
      6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22,
      6'd3,  6'd35, 6'd11, 6'd43, 6'd1,  6'd33, 6'd9,  6'd41,
      6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25,
      6'd15, 6'd47, 6'd7,  6'd39, 6'd13, 6'd45, 6'd5,  6'd37,
      6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21
   };

   function automatic logic [5:0] bayer_threshold(input logic [2:0] row,
                                                  input logic [2:0] col);
      return Bayer[{row, col}];
   endfunction

endpackage

// File: hdl/sbde_band_mem.sv
`timescale 1ns / 1ps

module sbde_band_mem (
   input  logic                       clock,
   input  sbde_pkg::mem_wr_type       wr,
   input  logic                       rd_en,
   input  logic [sbde_pkg::ColW-1:0]  rd_addr,
   output logic [sbde_pkg::LineW-1:0] rd_data
);
   import sbde_pkg::*;

   // one word per column, six cells side by side
   logic [LineW-1:0] mem_ff [MaxWidth];
   logic [LineW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr][wr.row*CellW +: CellW] <= wr.code;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/sbde_ctrl.sv
`timescale 1ns / 1ps

module sbde_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  sbde_pkg::action_type      action,
   input  logic [7:0]                red,
   input  logic [7:0]                green,
   input  logic [7:0]                blue,
   input  logic                      csr_write_en,
   input  sbde_pkg::reg_index_type   csr_index,
   input  logic [sbde_pkg::CfgW-1:0] csr_data,
   output sbde_pkg::mem_wr_type      mem_wr,
   output logic                      mem_rd_en,
   output logic [sbde_pkg::ColW-1:0] mem_rd_addr,
   output logic                      issue_valid,
   output sbde_pkg::issue_type       issue
);
   import sbde_pkg::*;

   logic [CfgW-1:0]   image_width_ff, image_width_in;
   logic              mono_mode_ff, mono_mode_in;
   logic [ColW-1:0]   fill_column_ff, fill_column_in;
   logic [RowW-1:0]   row_in_band_ff, row_in_band_in;
   logic [2:0]        phase_ff, phase_in;
   logic              band_waiting_ff, band_waiting_in;
   logic [PlaneW-1:0] emit_plane_ff, emit_plane_in;
   logic [PosW-1:0]   emit_pos_ff, emit_pos_in;

   logic [WidthW-1:0] eff_w;
   logic [1:0]        hund;
   logic [6:0]        rem;
   logic [14:0]       tens_prod;
   logic [3:0]        tens, ones;
   logic [1:0]        ndig;
   logic [PosW-1:0]   plen;
   logic [PosW-1:0]   dig_k, tail_k, col_off;
   logic [1:0]        dig_r;
   logic [3:0]        dig_val;
   logic [7:0]        pre_byte;

   logic              wrap, row_end;
   logic [ColW-1:0]   col_a;
   logic [ColW:0]     col_n;
   logic [RowW-1:0]   row_a;
   logic [2:0]        phase_a;
   logic [5:0]        thr;
   logic [7:0]        rb_sum_h, gl_sum_h;
   logic [8:0]        rb_sum, gl_sum;
   logic [5:0]        luma;
   logic [CellW-1:0]  pix_code;

   // clamp width into 1..MaxWidth
   always_comb begin
      if (image_width_ff == '0) begin
         eff_w = WidthW'(1);
      end else if (image_width_ff > CfgW'(MaxWidth)) begin
         eff_w = WidthW'(MaxWidth);
      end else begin
         eff_w = WidthW'(image_width_ff);
      end
   end

   // decimal digits of the width for the mono prefix
   always_comb begin
      if (eff_w >= WidthW'(200)) begin
         hund = 2'd2;
      end else if (eff_w >= WidthW'(100)) begin
         hund = 2'd1;
      end else begin
         hund = 2'd0;
      end
      rem       = 7'(eff_w - WidthW'(hund) * WidthW'(100));
      tens_prod = 15'(rem) * 15'd205;
      tens      = 4'(tens_prod >> 11);
      ones      = 4'(rem - 7'(tens) * 7'd10);
      if (eff_w >= WidthW'(100)) begin
         ndig = 2'd3;
      end else if (eff_w >= WidthW'(10)) begin
         ndig = 2'd2;
      end else begin
         ndig = 2'd1;
      end
      plen = mono_mode_ff ? PosW'(7) + PosW'(ndig) : PosW'(2);
   end

   // prefix byte at the current position
   always_comb begin
      dig_k   = emit_pos_ff - PosW'(3);
      tail_k  = emit_pos_ff - PosW'(3) - PosW'(ndig);
      dig_r   = ndig - 2'd1 - dig_k[1:0];
      case (dig_r)
         2'd0:    dig_val = ones;
         2'd1:    dig_val = tens;
         2'd2:    dig_val = {2'b00, hund};
         default: dig_val = 4'd0;
      endcase
      if (!mono_mode_ff) begin
         pre_byte = (emit_pos_ff == '0) ? ChrHash : ChrZero + {5'd0, emit_plane_ff[2:0]};
      end else if (emit_pos_ff == PosW'(0)) begin
         pre_byte = ChrHash;
      end else if (emit_pos_ff == PosW'(1)) begin
         pre_byte = ChrOne;
      end else if (emit_pos_ff == PosW'(2)) begin
         pre_byte = ChrBang;
      end else if (dig_k < PosW'(ndig)) begin
         pre_byte = ChrZero + {4'd0, dig_val};
      end else begin
         case (tail_k[1:0])
            2'd0:    pre_byte = ChrTilde;
            2'd1:    pre_byte = ChrDollar;
            2'd2:    pre_byte = ChrHash;
            default: pre_byte = ChrZero;
         endcase
      end
   end

   // pixel path: dither and place the cell
   always_comb begin
      wrap    = {1'b0, fill_column_ff} >= (ColW+1)'(eff_w);
      col_a   = wrap ? '0 : fill_column_ff;
      row_a   = wrap ? ((row_in_band_ff == RowW'(NumRows-1)) ? '0 : row_in_band_ff + 1'b1)
                     : row_in_band_ff;
      phase_a = wrap ? phase_ff + 3'd1 : phase_ff;
      thr     = bayer_threshold(phase_a, col_a[2:0]);
      rb_sum   = {1'b0, red} + {1'b0, blue};
      rb_sum_h = rb_sum[8:1];
      gl_sum   = {1'b0, rb_sum_h} + {1'b0, green};
      gl_sum_h = gl_sum[8:1];
      luma     = gl_sum_h[7:2];
      if (mono_mode_ff) begin
         pix_code = (luma >= thr) ? 3'd0 : 3'd1;
      end else begin
         pix_code = {blue[7:2] >= thr, green[7:2] >= thr, red[7:2] >= thr};
      end
      col_n   = {1'b0, col_a} + 1'b1;
      row_end = col_n >= (ColW+1)'(eff_w);
   end

   always_comb begin
      image_width_in  = image_width_ff;
      mono_mode_in    = mono_mode_ff;
      fill_column_in  = fill_column_ff;
      row_in_band_in  = row_in_band_ff;
      phase_in        = phase_ff;
      band_waiting_in = band_waiting_ff;
      emit_plane_in   = emit_plane_ff;
      emit_pos_in     = emit_pos_ff;
      mem_wr          = '0;
      mem_rd_en       = 1'b0;
      col_off         = emit_pos_ff - plen;
      mem_rd_addr     = col_off[ColW-1:0];
      issue_valid     = 1'b0;
      issue           = '0;
      issue.plane     = emit_plane_ff[2:0];
      issue.mono      = mono_mode_ff;

      if (csr_write_en) begin
         case (csr_index)
            REG_IMAGE_WIDTH: image_width_in = csr_data;
            REG_MONO_MODE:   mono_mode_in   = csr_data[0];
            default:         ;
         endcase
      end

      if (accept) begin
         case (action)
            ACT_PIXEL: begin
               if (!band_waiting_ff) begin
                  mem_wr.en   = 1'b1;
                  mem_wr.addr = col_a;
                  mem_wr.row  = row_a;
                  mem_wr.code = pix_code;
                  if (row_end) begin
                     fill_column_in = '0;
                     phase_in       = phase_a + 3'd1;
                     if (row_a == RowW'(NumRows-1)) begin
                        row_in_band_in  = '0;
                        band_waiting_in = 1'b1;
                        emit_plane_in   = '0;
                        emit_pos_in     = '0;
                     end else begin
                        row_in_band_in = row_a + 1'b1;
                     end
                  end else begin
                     fill_column_in = col_n[ColW-1:0];
                     row_in_band_in = row_a;
                     phase_in       = phase_a;
                  end
               end
            end
            ACT_PULL: begin
               issue_valid = 1'b1;
               if (!band_waiting_ff) begin
                  issue.nothing_ready = 1'b1;
               end else if (emit_plane_ff >= (mono_mode_ff ? PlaneW'(1) : PlaneW'(8))) begin
                  issue.out_byte  = ChrDash;
                  issue.band_end  = 1'b1;
                  band_waiting_in = 1'b0;
                  emit_plane_in   = '0;
                  emit_pos_in     = '0;
               end else if (emit_pos_ff < plen) begin
                  issue.out_byte = pre_byte;
                  emit_pos_in    = emit_pos_ff + 1'b1;
               end else if (emit_pos_ff < plen + PosW'(eff_w)) begin
                  // column byte is formed when the word comes back
                  issue.is_column = 1'b1;
                  mem_rd_en       = 1'b1;
                  emit_pos_in     = emit_pos_ff + 1'b1;
               end else begin
                  issue.out_byte = ChrDollar;
                  emit_plane_in  = emit_plane_ff + 1'b1;
                  emit_pos_in    = '0;
               end
            end
            ACT_NEW_IMAGE: begin
               fill_column_in  = '0;
               row_in_band_in  = '0;
               phase_in        = '0;
               band_waiting_in = 1'b0;
               emit_plane_in   = '0;
               emit_pos_in     = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= CfgW'(MaxWidth);
         mono_mode_ff    <= 1'b0;
         fill_column_ff  <= '0;
         row_in_band_ff  <= '0;
         phase_ff        <= '0;
         band_waiting_ff <= 1'b0;
         emit_plane_ff   <= '0;
         emit_pos_ff     <= '0;
      end else begin
         image_width_ff  <= image_width_in;
         mono_mode_ff    <= mono_mode_in;
         fill_column_ff  <= fill_column_in;
         row_in_band_ff  <= row_in_band_in;
         phase_ff        <= phase_in;
         band_waiting_ff <= band_waiting_in;
         emit_plane_ff   <= emit_plane_in;
         emit_pos_ff     <= emit_pos_in;
      end
   end

endmodule

// File: hdl/sbde_emit.sv
`timescale 1ns / 1ps

module sbde_emit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       issue_valid,
   input  sbde_pkg::issue_type        issue,
   input  logic [sbde_pkg::LineW-1:0] rd_data,
   output logic                       ready,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_band_end,
   output logic                       rsp_nothing_ready
);
   import sbde_pkg::*;

   logic      p1_valid_ff, p1_valid_in;
   issue_type p1_ff;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_byte_ff;
   logic      band_end_ff, nothing_ready_ff;
   logic      out_free, p1_adv;
   logic [5:0] bits;
   logic [7:0] byte_mux;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign p1_adv   = p1_valid_ff && out_free;
   assign ready    = !p1_valid_ff || p1_adv;

   // one bit per row: colour match, or the dark bit in mono
   always_comb begin
      for (int j = 0; j < NumRows; j++) begin
         bits[j] = p1_ff.mono ? rd_data[j*CellW] : (rd_data[j*CellW +: CellW] == p1_ff.plane);
      end
      byte_mux = p1_ff.is_column ? ChrBase + {2'b00, bits} : p1_ff.out_byte;
   end

   always_comb begin
      p1_valid_in  = ready ? issue_valid : p1_valid_ff;
      rsp_valid_in = p1_adv || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff  <= p1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready && issue_valid) begin
         p1_ff <= issue;
      end
      if (p1_adv) begin
         out_byte_ff      <= byte_mux;
         band_end_ff      <= p1_ff.band_end;
         nothing_ready_ff <= p1_ff.nothing_ready;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = out_byte_ff;
   assign rsp_band_end      = band_end_ff;
   assign rsp_nothing_ready = nothing_ready_ff;

endmodule

// File: hdl/sixel_band_dither_encoder_unit.sv
`timescale 1ns / 1ps
// channel  ports                                        word
// req      req_valid, req_stall, req_action, req_red,   one pixel, pull or restart
//          req_green, req_blue
// rsp      rsp_valid, rsp_stall, rsp_out_byte,          one sixel text byte per pull
//          rsp_band_end, rsp_nothing_ready
// csr      csr_write_en, csr_index, csr_data            width / mono register write
//
// One word is taken per cycle while req_stall is low; a pull's byte passes through
// the band memory read and issue register at the accept edge, then the output register.
// Pixels write one cell of the band memory in the accept cycle; pulls
// read one six-cell column word from the same memory.
// Reset is synchronous and clears control state only; band memory is not cleared.
// rsp_stall backs up through the read stage to req_stall with no bubble.

module sixel_band_dither_encoder_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  sbde_pkg::action_type      req_action,
   input  logic [7:0]                req_red,
   input  logic [7:0]                req_green,
   input  logic [7:0]                req_blue,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_band_end,
   output logic                      rsp_nothing_ready,
   input  logic                      csr_write_en,
   input  sbde_pkg::reg_index_type   csr_index,
   input  logic [sbde_pkg::CfgW-1:0] csr_data
);
   import sbde_pkg::*;

   logic             accept;
   logic             ready;
   mem_wr_type       mem_wr;
   logic             mem_rd_en;
   logic [ColW-1:0]  mem_rd_addr;
   logic [LineW-1:0] mem_rd_data;
   logic             issue_valid;
   issue_type        issue;

   assign req_stall = !ready;
   assign accept    = req_valid && ready;

   sbde_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .action       (req_action),
      .red          (req_red),
      .green        (req_green),
      .blue         (req_blue),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .mem_wr       (mem_wr),
      .mem_rd_en    (mem_rd_en),
      .mem_rd_addr  (mem_rd_addr),
      .issue_valid  (issue_valid),
      .issue        (issue)
   );

   sbde_band_mem u_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   sbde_emit u_emit (
      .clock             (clock),
      .reset             (reset),
      .issue_valid       (issue_valid),
      .issue             (issue),
      .rd_data           (mem_rd_data),
      .ready             (ready),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_band_end      (rsp_band_end),
      .rsp_nothing_ready (rsp_nothing_ready)
   );

   a_end_is_dash: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_band_end |-> rsp_out_byte == ChrDash && !rsp_nothing_ready)
      else $error("band end word is not a dash");

   a_empty_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_nothing_ready |-> rsp_out_byte == 8'd0)
      else $error("empty pull carries a nonzero byte");

   a_printable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_nothing_ready |-> rsp_out_byte >= ChrBang && rsp_out_byte <= ChrTilde)
      else $error("band byte outside printable range");

   a_no_word_from_nothing: assert property (@(posedge clock) disable iff (reset)
      !req_valid && !rsp_valid && !req_stall |=> !rsp_valid || $past(rsp_valid, 2)
      || $past(req_valid, 2))
      else $error("result word without a pull");

endmodule
